@@ rtl/can_frame_to_slcan_text_assert.svh @@
// Assertion macros shared by the frame text encoder.
`ifndef CAN_FRAME_TO_SLCAN_TEXT_ASSERT_SVH
`define CAN_FRAME_TO_SLCAN_TEXT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CFST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define CFST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/cfst_pkg.sv @@
// Shared types, constants and helpers of the frame text encoder.
package cfst_pkg;

  localparam logic [3:0] MAX_DATA_BYTES = 4'd8;

  localparam logic [7:0] CHAR_STD_DATA = 8'h74;  // t
  localparam logic [7:0] CHAR_STD_RTR  = 8'h72;  // r
  localparam logic [7:0] CHAR_EXT_DATA = 8'h54;  // T
  localparam logic [7:0] CHAR_EXT_RTR  = 8'h52;  // R

  localparam logic [3:0] STD_ID_DIGITS = 4'd3;
  localparam logic [3:0] EXT_ID_DIGITS = 4'd8;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // One classified frame, ready to be spelled out.
  typedef struct packed {
    logic [7:0]  type_char;
    logic [3:0]  id_digits;
    logic [28:0] id;
    logic [3:0]  len_digit;
    logic [3:0]  n_bytes;
    logic [63:0] data;
  } desc_t;

  typedef struct packed {
    logic       valid;
    logic       full;
    logic [1:0] count;
  } q_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

endpackage

@@ rtl/cfst_front.sv @@
// Front stage: accept a frame and classify it into a descriptor.
module cfst_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        sid_high,
  input  logic [7:0]        sid_low,
  input  logic [7:0]        eid_high,
  input  logic [7:0]        eid_low,
  input  logic [7:0]        length_reg,
  input  logic [63:0]       payload,
  input  logic              q_full,
  output logic              q_wr,
  output cfst_pkg::desc_t   q_data,
  output logic              front_valid
);

  logic            accept;
  logic            ext;
  logic            remote;
  logic [10:0]     sid;
  logic [3:0]      cnt;
  cfst_pkg::desc_t desc_next;
  cfst_pkg::desc_t desc;

  assign full   = front_valid && q_full;
  assign accept = push && !full;
  assign q_wr   = front_valid && !q_full;
  assign q_data = desc;

  always_comb begin
    ext    = sid_low[3];
    remote = length_reg[6];
    sid    = {sid_high, sid_low[7:5]};
    cnt    = (length_reg[3:0] > cfst_pkg::MAX_DATA_BYTES) ?
             cfst_pkg::MAX_DATA_BYTES : length_reg[3:0];
    if (ext) begin
      desc_next.type_char = remote ? cfst_pkg::CHAR_EXT_RTR : cfst_pkg::CHAR_EXT_DATA;
      desc_next.id_digits = cfst_pkg::EXT_ID_DIGITS;
      desc_next.id        = {sid, sid_low[1:0], eid_high, eid_low};
    end else begin
      desc_next.type_char = remote ? cfst_pkg::CHAR_STD_RTR : cfst_pkg::CHAR_STD_DATA;
      desc_next.id_digits = cfst_pkg::STD_ID_DIGITS;
      desc_next.id        = {18'd0, sid};
    end
    desc_next.len_digit = cnt;
    desc_next.n_bytes   = remote ? 4'd0 : cnt;
    desc_next.data      = payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (q_wr) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc <= desc_next;
    end
  end

endmodule

@@ rtl/cfst_queue.sv @@
// Two-entry descriptor queue between the front and back stages.
module cfst_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  cfst_pkg::desc_t       wr_data,
  input  logic                  rd,
  output cfst_pkg::desc_t       rd_data,
  output cfst_pkg::q_status_t   status
);

  cfst_pkg::desc_t mem [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign rd_data      = mem[rptr];
  assign status.count = count;
  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

@@ rtl/cfst_back.sv @@
// Back stage: spell the head descriptor out one character a cycle unless the output stalls.
module cfst_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cfst_pkg::desc_t   head,
  output logic              head_done,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        text_char,
  output logic              last_char
);

  logic [4:0]  pos;
  logic [4:0]  pos_next;
  logic        out_valid;
  logic        adv;
  logic [4:0]  idlen;
  logic [4:0]  id_sel;
  logic [4:0]  data_sel;
  logic [4:0]  pos_last;
  logic [31:0] id32;
  logic [3:0]  nib;
  logic [7:0]  char_next;
  logic        last_next;

  assign empty     = !out_valid;
  assign adv       = head_valid && (!out_valid || pop);
  assign head_done = adv && last_next;

  always_comb begin
    idlen     = {1'b0, head.id_digits};
    id_sel    = idlen - pos;
    data_sel  = pos - idlen - 5'd2;
    pos_last  = idlen + 5'd1 + {head.n_bytes, 1'b0};
    id32      = {3'd0, head.id};
    nib       = 4'd0;
    if (pos == 5'd0) begin
      char_next = head.type_char;
    end else if (pos <= idlen) begin
      nib       = id32[{id_sel[2:0], 2'b00} +: 4];
      char_next = cfst_pkg::hex_char(nib);
    end else if (pos == idlen + 5'd1) begin
      char_next = cfst_pkg::hex_char(head.len_digit);
    end else begin
      // high nibble of each byte first
      nib       = head.data[{data_sel[3:1], ~data_sel[0], 2'b00} +: 4];
      char_next = cfst_pkg::hex_char(nib);
    end
    last_next = (pos == pos_last);
    pos_next  = last_next ? 5'd0 : pos + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 5'd0;
      out_valid <= 1'b0;
    end else if (adv) begin
      pos       <= pos_next;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      text_char <= char_next;
      last_char <= last_next;
    end
  end

endmodule

@@ rtl/can_frame_to_slcan_text.sv @@
// Top level of the CAN frame to serial-line ASCII text encoder.
//
//   channel   handshake       words           width
//   frame in  push / full     one CAN frame   5 x 8 + 64 bits
//   text out  pop / empty     one character   8 + 1 bits
//
// A frame yields 5 to 26 characters; the back sequencer emits one character
// per cycle through its single output register unless the output stalls.
// The front register and a two-entry queue take up to three frames ahead.
// Reset (rst, synchronous) empties the front register, the queue and the
// output register; no clearing pass.
// A stalled output holds its character; the front keeps accepting until the
// queue and the front register are both full, then raises full.
`include "can_frame_to_slcan_text_assert.svh"

module can_frame_to_slcan_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  sid_high,
  input  logic [7:0]  sid_low,
  input  logic [7:0]  eid_high,
  input  logic [7:0]  eid_low,
  input  logic [7:0]  length_reg,
  input  logic [63:0] payload,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  text_char,
  output logic        last_char
);

  logic                q_wr;
  logic                q_full;
  logic                front_valid;
  logic                head_done;
  logic                out_is_type;
  cfst_pkg::desc_t     q_in;
  cfst_pkg::desc_t     q_head;
  cfst_pkg::q_status_t q_stat;

  assign q_full = q_stat.full;

  // The word on the output is one of the four frame type letters.
  assign out_is_type = text_char inside {cfst_pkg::CHAR_STD_DATA, cfst_pkg::CHAR_STD_RTR,
                                         cfst_pkg::CHAR_EXT_DATA, cfst_pkg::CHAR_EXT_RTR};

  // Classify each accepted frame into a descriptor.
  cfst_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sid_high    (sid_high),
    .sid_low     (sid_low),
    .eid_high    (eid_high),
    .eid_low     (eid_low),
    .length_reg  (length_reg),
    .payload     (payload),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_data      (q_in),
    .front_valid (front_valid)
  );

  // Decouple the front from the character sequencer.
  cfst_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_in),
    .rd      (head_done),
    .rd_data (q_head),
    .status  (q_stat)
  );

  // Walk the head descriptor; drop it after its last character is loaded.
  cfst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_stat.valid),
    .head       (q_head),
    .head_done  (head_done),
    .pop        (pop),
    .empty      (empty),
    .text_char  (text_char),
    .last_char  (last_char)
  );

  `CFST_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, q_stat.count <= 2'd2)
  `CFST_ASSERT_NOW(a_full_needs_front, clk, rst, full, front_valid && q_stat.full)
  `CFST_ASSERT_NEXT(a_type_after_last, clk, rst, (!empty && pop && last_char), (empty || out_is_type))

endmodule
